// File: src/mmfs_pkg.sv
// Shared widths, codes and types of the min-max feature scaler.
package mmfs_pkg;

   localparam int VALUE_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int COL_W     = 6;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;
   localparam int CNT_W     = $clog2(VALUE_W);

   localparam int FEATURES_DEFAULT = 64;
   localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 7'd64;

   // Stream payload layout, padded to whole bytes
   localparam int REQ_DATA_BITS = COL_W + VALUE_W;
   localparam int REQ_TDATA_W   = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = VALUE_W + COL_W;
   localparam int RSP_TDATA_W   = ((RSP_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_TDATA_W - RSP_DATA_BITS;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_CLEAR = 2'd0;
   localparam kind_type KIND_FIT   = 2'd1;
   localparam kind_type KIND_XFORM = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_UNFIT = 2'd2;

   // One column's running bounds
   typedef struct packed {
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
   } entry_type;

endpackage

// File: src/min_max_feature_scaler_core.sv
// Min-max feature scaler: per-column running bounds and a sequenced divider.
//
// Items arrive on the req_ stream: tuser carries the kind (clear, fit, transform),
// tdata the column and a signed Q16.16 value. Each item yields exactly one rsp_
// item with the scaled value, a status in tuser and the column echoed. A fit updates
// the stored bounds, a transform scales against them. One shared 33-bit subtractor
// does the bound compares, the range and magnitude, the overflow check, one restoring
// divide step per cycle for the 32 quotient bits and the negation of the quotient.
// req_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next item can be taken and worked on before the
// previous result is consumed. csr_wdata sets the number of feature columns in use
// (reset 64); the user must write it only while idle; the block does not check it.
module min_max_feature_scaler_core #(
   parameter int FEATURES = mmfs_pkg::FEATURES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: column [5:0], value [37:6], zero pad above
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mmfs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: kind [1:0]
   input  logic [mmfs_pkg::KIND_W-1:0]        req_tuser,
   // rsp_tdata: scaled [31:0], column_echo [37:32], zero pad above
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mmfs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [mmfs_pkg::STATUS_W-1:0]      rsp_tuser,
   input  logic                               csr_wen,
   input  logic [mmfs_pkg::COUNT_W-1:0]       csr_wdata
);
   import mmfs_pkg::*;

   localparam int ADDR_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int SUB_W  = VALUE_W + 1;
   localparam logic [VALUE_W-1:0] SMIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] SMAX = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_FIT_LO, S_FIT_HI, S_RANGE, S_MAG, S_MAG_NEG, S_PRE, S_DIV, S_DONE
   } state_type;

   function automatic logic [VALUE_W-1:0] key(input logic [VALUE_W-1:0] v);
      key = v ^ SMIN;
   endfunction

   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   status_type           status_ff, status_in;
   logic [FEATURES-1:0]  fitted_ff, fitted_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0]   new_lo_ff, new_lo_in;
   logic [VALUE_W-1:0]   range_ff, range_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [VALUE_W-1:0]   rem_ff, rem_in;
   logic [VALUE_W-1:0]   num_ff, num_in;
   logic [VALUE_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 over_ff, over_in;
   logic                 calc_ff, calc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_scaled_ff, rsp_scaled_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COL_W-1:0]     rsp_col_ff, rsp_col_in;

   // Shared subtractor
   logic [SUB_W-1:0]     sub_a, sub_b;
   logic [SUB_W:0]       sub_diff;
   logic                 sub_borrow;

   // Request fields
   kind_type             req_kind;
   logic [COL_W-1:0]     req_col;
   logic [VALUE_W-1:0]   req_val;
   logic                 req_accept;
   logic                 req_in_range;

   // Store ports
   logic                 wr_en;
   entry_type            wr_data;
   logic                 rd_en;
   entry_type            rd_data;
   logic [ADDR_W-1:0]    col_addr;
   logic                 sat;

   assign req_kind     = req_tuser;
   assign req_col      = req_tdata[COL_W-1:0];
   assign req_val      = req_tdata[COL_W +: VALUE_W];
   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_in_range = (COUNT_W'(req_col) < count_ff) && (int'(req_col) < FEATURES);
   assign col_addr     = ADDR_W'(col_ff);

   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[SUB_W];
   assign sat        = over_ff | quo_ff[VALUE_W-1];

   mmfs_store #(
      .DEPTH  (FEATURES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ADDR_W'(req_col)),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      fitted_in     = fitted_ff;
      count_in      = count_ff;
      new_lo_in     = new_lo_ff;
      range_in      = range_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      over_in       = over_ff;
      calc_in       = calc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_scaled_in = rsp_scaled_ff;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      sub_a         = '0;
      sub_b         = '0;
      wr_en         = 1'b0;
      wr_data       = '{lo: val_ff, hi: val_ff};
      rd_en         = 1'b0;

      if (csr_wen) begin
         count_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in   = req_kind;
               col_in    = req_col;
               val_in    = req_val;
               status_in = ST_OK;
               calc_in   = 1'b0;
               over_in   = 1'b0;
               state_in  = S_DONE;
               if (req_kind == KIND_CLEAR) begin
                  fitted_in = '0;
               end else if (req_kind == KIND_FIT || req_kind == KIND_XFORM) begin
                  if (!req_in_range) begin
                     status_in = ST_RANGE;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            if (kind_ff == KIND_FIT) begin
               if (!fitted_ff[col_addr]) begin
                  // first sample of the column sets both bounds
                  wr_en                = 1'b1;
                  fitted_in[col_addr]  = 1'b1;
                  state_in             = S_DONE;
               end else begin
                  state_in = S_FIT_LO;
               end
            end else if (!fitted_ff[col_addr]) begin
               status_in = ST_UNFIT;
               state_in  = S_DONE;
            end else begin
               state_in = S_RANGE;
            end
         end
         S_FIT_LO: begin
            sub_a     = SUB_W'(key(val_ff));
            sub_b     = SUB_W'(key(rd_data.lo));
            new_lo_in = sub_borrow ? val_ff : rd_data.lo;
            state_in  = S_FIT_HI;
         end
         S_FIT_HI: begin
            sub_a      = SUB_W'(key(rd_data.hi));
            sub_b      = SUB_W'(key(val_ff));
            wr_en      = 1'b1;
            wr_data.lo = new_lo_ff;
            wr_data.hi = sub_borrow ? val_ff : rd_data.hi;
            state_in   = S_DONE;
         end
         S_RANGE: begin
            sub_a    = SUB_W'(key(rd_data.hi));
            sub_b    = SUB_W'(key(rd_data.lo));
            range_in = sub_diff[VALUE_W-1:0];
            state_in = S_MAG;
         end
         S_MAG: begin
            sub_a  = SUB_W'(key(val_ff));
            sub_b  = SUB_W'(key(rd_data.lo));
            neg_in = sub_borrow;
            mag_in = sub_diff[VALUE_W-1:0];
            if (range_ff == '0) begin
               state_in = S_DONE;
            end else if (sub_borrow) begin
               state_in = S_MAG_NEG;
            end else begin
               state_in = S_PRE;
            end
         end
         S_MAG_NEG: begin
            sub_a    = SUB_W'(key(rd_data.lo));
            sub_b    = SUB_W'(key(val_ff));
            mag_in   = sub_diff[VALUE_W-1:0];
            state_in = S_PRE;
         end
         S_PRE: begin
            // integer part of the magnitude at or above range means q >= 2^VALUE_W
            sub_a    = SUB_W'(mag_ff >> FRAC_BITS);
            sub_b    = SUB_W'(range_ff);
            calc_in  = 1'b1;
            rem_in   = mag_ff >> FRAC_BITS;
            num_in   = mag_ff << (VALUE_W - FRAC_BITS);
            quo_in   = '0;
            cnt_in   = '0;
            if (!sub_borrow) begin
               over_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            sub_a  = {rem_ff, num_ff[VALUE_W-1]};
            sub_b  = SUB_W'(range_ff);
            rem_in = sub_borrow ? {rem_ff[VALUE_W-2:0], num_ff[VALUE_W-1]}
                                : sub_diff[VALUE_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], !sub_borrow};
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // negate the quotient through the shared unit
            sub_a = '0;
            sub_b = SUB_W'(quo_ff);
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_col_in    = col_ff;
               if (!calc_ff) begin
                  rsp_scaled_in = '0;
               end else if (neg_ff) begin
                  rsp_scaled_in = sat ? SMIN : sub_diff[VALUE_W-1:0];
               end else begin
                  rsp_scaled_in = sat ? SMAX : quo_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fitted_ff    <= '0;
         count_ff     <= COLUMN_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fitted_ff    <= fitted_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      col_ff        <= col_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      new_lo_ff     <= new_lo_in;
      range_ff      <= range_in;
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      neg_ff        <= neg_in;
      over_ff       <= over_in;
      calc_ff       <= calc_in;
      rsp_scaled_ff <= rsp_scaled_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_col_ff, rsp_scaled_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: src/mmfs_store.sv
// Per-column minimum/maximum memory with one write port and a registered read port.
module mmfs_store #(
   parameter int DEPTH  = mmfs_pkg::FEATURES_DEFAULT,
   parameter int ADDR_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  mmfs_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output mmfs_pkg::entry_type rd_data
);
   import mmfs_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/sv/scaler_answer_check.sv
`timescale 1ns / 1ps
// Checker of the min-max feature scaler: watches both streams, predicts each answer, compares.
module scaler_answer_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [mmfs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [mmfs_pkg::KIND_W-1:0]      req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [mmfs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [mmfs_pkg::STATUS_W-1:0]    rsp_tuser,
   input  logic                             csr_wen,
   input  logic [mmfs_pkg::COUNT_W-1:0]     csr_wdata,
   output int                               fail_count,
   output int                               pending_results
);
   import mmfs_pkg::*;

   localparam int COLUMNS = FEATURES_DEFAULT;
   localparam logic [63:0] QUOTIENT_CAP = 64'h0000_0000_8000_0000;
   localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] SATURATED_HIGH = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [VALUE_W-1:0] scaled;
      status_type         status;
      logic [COL_W-1:0]   column;
   } answer_type;

   answer_type          expected_answers [$];
   answer_type          want;
   entry_type           bounds [COLUMNS];
   logic [COLUMNS-1:0]  fitted = '0;
   logic [COUNT_W-1:0]  columns_in_use = COLUMN_COUNT_RESET;
   int                  errors_seen = 0;

   // Work out the answer to one item and fold it into the running bounds
   function automatic answer_type scale_item(kind_type kind, logic [COL_W-1:0] col,
                                             logic [VALUE_W-1:0] val);
      answer_type  a;
      logic [63:0] kv, kmin, kmax, span, mag, quo;
      logic        in_range;
      a.scaled = '0;
      a.status = ST_OK;
      a.column = col;
      in_range = ({1'b0, col} < columns_in_use) && (col < COLUMNS);
      case (kind)
         KIND_CLEAR: begin
            fitted = '0;
         end
         KIND_FIT, KIND_XFORM: begin
            if (!in_range) begin
               a.status = ST_RANGE;
            end else if (kind == KIND_FIT) begin
               if (!fitted[col]) begin
                  bounds[col].lo = val;
                  bounds[col].hi = val;
                  fitted[col] = 1'b1;
               end else begin
                  if ($signed(val) < $signed(bounds[col].lo)) bounds[col].lo = val;
                  if ($signed(val) > $signed(bounds[col].hi)) bounds[col].hi = val;
               end
            end else if (!fitted[col]) begin
               a.status = ST_UNFIT;
            end else begin
               // offset keys keep signed order as unsigned order
               kv   = {32'b0, val ^ SIGN_FLIP};
               kmin = {32'b0, bounds[col].lo ^ SIGN_FLIP};
               kmax = {32'b0, bounds[col].hi ^ SIGN_FLIP};
               span = kmax - kmin;
               if (span != 0) begin
                  mag = (kv < kmin) ? kmin - kv : kv - kmin;
                  quo = (mag << FRAC_BITS) / span;
                  if (quo > QUOTIENT_CAP) quo = QUOTIENT_CAP;
                  if (kv < kmin) a.scaled = ~quo[VALUE_W-1:0] + 1'b1;
                  else if (quo >= QUOTIENT_CAP) a.scaled = SATURATED_HIGH;
                  else a.scaled = quo[VALUE_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         columns_in_use = COLUMN_COUNT_RESET;
         fitted = '0;
         expected_answers.delete();
      end else begin
         if (csr_wen) columns_in_use = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $error("result with nothing expected: scaled %h, status %0d, column_echo %0d",
                      rsp_tdata[VALUE_W-1:0], rsp_tuser, rsp_tdata[VALUE_W+COL_W-1:VALUE_W]);
               errors_seen++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata[VALUE_W-1:0] !== want.scaled) begin
                  $error("scaled: expected %h, actual %h", want.scaled, rsp_tdata[VALUE_W-1:0]);
                  errors_seen++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
                  errors_seen++;
               end
               if (rsp_tdata[VALUE_W+COL_W-1:VALUE_W] !== want.column) begin
                  $error("column_echo: expected %0d, actual %0d", want.column,
                         rsp_tdata[VALUE_W+COL_W-1:VALUE_W]);
                  errors_seen++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_answers.push_back(scale_item(req_tuser, req_tdata[COL_W-1:0],
                                                  req_tdata[COL_W+VALUE_W-1:COL_W]));
      end
      pending_results <= expected_answers.size();
      fail_count      <= errors_seen;
   end

endmodule

// File: tb/sv/min_max_feature_scaler_core_tb.sv
`timescale 1ns / 1ps
// Top of the min-max feature scaler testbench: clock, reset, stimulus and verdict.
module min_max_feature_scaler_core_tb;
   import mmfs_pkg::*;

   localparam kind_type KIND_UNUSED = 2'd3;
   localparam int RUN_LIMIT      = 400_000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int TAIL_CYCLES    = 50;
   localparam int PHASES         = 8;
   localparam logic [VALUE_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {FLOW_OPEN, FLOW_HALF, FLOW_MOSTLY, FLOW_PERIODIC} flow_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   kind_type               req_tuser = KIND_CLEAR;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   status_type             rsp_tuser;
   logic                   csr_wen = 1'b0;
   logic [COUNT_W-1:0]     csr_wdata = '0;

   int                     pending_results;
   int                     fail_count;
   int unsigned            burst_left = 1;
   logic [COUNT_W-1:0]     count_now = COLUMN_COUNT_RESET;
   logic [7:0]             holdoff_req = '0;
   logic [7:0]             holdoff_ack = '0;
   int unsigned            holdoff_left = 0;
   int unsigned            flow_tick = 0;
   flow_mode_type          flow_mode = FLOW_OPEN;
   int unsigned            count_plan [PHASES] = '{64, 1, 37, 127, 0, 8, 64, 100};
   int unsigned            size_plan [PHASES]  = '{90, 60, 90, 80, 30, 90, 90, 80};

   min_max_feature_scaler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   scaler_answer_check answer_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Result side: long hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      flow_tick <= flow_tick + 1;
      if (holdoff_left != 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_req != holdoff_ack) begin
         rsp_tready   <= 1'b0;
         holdoff_ack  <= holdoff_req;
         holdoff_left <= HOLDOFF_CYCLES;
      end else begin
         if (flow_tick % 96 == 0) flow_mode <= flow_mode_type'($urandom_range(0, 3));
         case (flow_mode)
            FLOW_OPEN:     rsp_tready <= 1'b1;
            FLOW_HALF:     rsp_tready <= ($urandom_range(0, 1) == 1);
            FLOW_MOSTLY:   rsp_tready <= ($urandom_range(0, 4) != 0);
            FLOW_PERIODIC: rsp_tready <= (flow_tick % 5 < 2);
            default:       rsp_tready <= 1'b1;
         endcase
      end
   end

   // Offer one item, hold it until taken, then maybe close the burst with a gap
   task automatic send_item(kind_type kind, logic [COL_W-1:0] col, logic [VALUE_W-1:0] val);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W - REQ_DATA_BITS){1'b0}}, val, col};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 1) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait until every answer is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_count(logic [COUNT_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      count_now  = value;
   endtask

   function automatic int unsigned COLUMNS_USED();
      return FEATURES_DEFAULT;
   endfunction

   // Random fit/transform traffic on a small window of columns, some noise mixed in
   task automatic run_phase(int unsigned n_items, bit with_holdoff);
      int unsigned        span_cols, win, base, pick, n;
      logic [COL_W-1:0]   col;
      logic [VALUE_W-1:0] center, spread, val;
      kind_type           kind;
      span_cols = (count_now > COLUMNS_USED()) ? COLUMNS_USED() : count_now;
      win       = (span_cols > 8) ? 8 : span_cols;
      base      = (span_cols > win) ? $urandom_range(0, span_cols - win) : 0;
      center    = $urandom;
      spread    = 32'd1 << $urandom_range(2, 31);
      if ($urandom_range(0, 1) == 1) send_item(KIND_CLEAR, COL_W'($urandom_range(0, 63)), $urandom);
      for (n = 0; n < n_items; n++) begin
         if (with_holdoff && n == n_items / 2) holdoff_req <= holdoff_req + 8'd1;
         if (win == 0 || $urandom_range(0, 9) == 0) col = COL_W'($urandom_range(0, 63));
         else col = COL_W'(base + $urandom_range(0, win - 1));
         case ($urandom_range(0, 9))
            0: val = $urandom;
            1: begin
               case ($urandom_range(0, 3))
                  0:       val = MOST_NEGATIVE;
                  1:       val = MOST_POSITIVE;
                  2:       val = '0;
                  default: val = '1;
               endcase
            end
            default: val = center + $urandom_range(0, spread) - (spread >> 1);
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 3) kind = KIND_CLEAR;
         else if (pick < 45) kind = KIND_FIT;
         else if (pick < 95) kind = KIND_XFORM;
         else kind = KIND_UNUSED;
         send_item(kind, col, val);
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // never fitted
      send_item(KIND_XFORM, 6'd5, 32'h0000_0000);
      // full signed range on one column
      send_item(KIND_FIT,   6'd0, MOST_NEGATIVE);
      send_item(KIND_FIT,   6'd0, MOST_POSITIVE);
      send_item(KIND_XFORM, 6'd0, 32'h0000_0000);
      send_item(KIND_XFORM, 6'd0, MOST_NEGATIVE);
      send_item(KIND_XFORM, 6'd0, MOST_POSITIVE);
      // zero range
      send_item(KIND_FIT,   6'd63, 32'h0005_0000);
      send_item(KIND_XFORM, 6'd63, 32'h0005_0000);
      send_item(KIND_XFORM, 6'd63, 32'hFFF9_0000);
      // one-lsb range: far outside saturates both ways
      send_item(KIND_FIT,   6'd1, 32'h0000_0000);
      send_item(KIND_FIT,   6'd1, 32'h0000_0001);
      send_item(KIND_XFORM, 6'd1, MOST_POSITIVE);
      send_item(KIND_XFORM, 6'd1, MOST_NEGATIVE);
      // midpoint
      send_item(KIND_FIT,   6'd2, 32'h0001_0000);
      send_item(KIND_FIT,   6'd2, 32'h0003_0000);
      send_item(KIND_XFORM, 6'd2, 32'h0002_0000);
      send_item(KIND_UNUSED, 6'd63, 32'hFFFF_FFFF);
      // clear drops every fit
      send_item(KIND_CLEAR, 6'd42, 32'h1234_5678);
      send_item(KIND_XFORM, 6'd0, 32'h0000_0000);
      drain();

      write_count(7'd1);
      send_item(KIND_FIT,   6'd1, 32'h0000_0000);
      send_item(KIND_XFORM, 6'd0, 32'h0000_0000);
      send_item(KIND_FIT,   6'd0, 32'hFFFF_0000);
      send_item(KIND_XFORM, 6'd0, 32'h0100_0000);
      send_item(KIND_XFORM, 6'd63, 32'h0000_0000);
      drain();
      write_count(7'd0);
      send_item(KIND_FIT,   6'd0, 32'h0000_0000);
      drain();
      write_count(7'd127);
      send_item(KIND_FIT,   6'd63, 32'hFFFF_FFFF);
      send_item(KIND_XFORM, 6'd63, 32'h0000_0000);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         write_count(COUNT_W'(count_plan[p]));
         run_phase(size_plan[p], p == 2);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("min_max_feature_scaler_core_tb: PASS");
      else $display("min_max_feature_scaler_core_tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("min_max_feature_scaler_core_tb: FAIL");
      $finish;
   end

endmodule

// File: filelist.f
src/mmfs_pkg.sv
src/mmfs_store.sv
src/min_max_feature_scaler_core.sv
tb/sv/scaler_answer_check.sv
tb/sv/min_max_feature_scaler_core_tb.sv
